/* sv/kbsc_pkg.sv */
// ----------------------------------------------------------------------------
// kbsc_pkg
// Shared types, operation codes and constants of the keyed byte stream cipher.
// ----------------------------------------------------------------------------
package kbsc_pkg;

  localparam int unsigned KeyWords   = 4;
  localparam int unsigned KeyIdxW    = 2;
  localparam int unsigned WordW      = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned OpW        = 2;

  localparam logic [WordW-1:0] InitConst   = 32'h4a434c41;
  localparam logic [WordW-1:0] GoldenConst = 32'h9e3779b9;
  localparam logic [WordW-1:0] LcgMul      = 32'd1664525;
  localparam logic [WordW-1:0] LcgAdd      = 32'd1013904223;

  typedef enum logic [OpW-1:0] {
    OP_START = 2'd0,
    OP_NONCE = 2'd1,
    OP_DATA  = 2'd2
  } op_e;

  // key register indexes
  localparam logic [KeyIdxW-1:0] KEY_WORD_ZERO  = 2'd0;
  localparam logic [KeyIdxW-1:0] KEY_WORD_ONE   = 2'd1;
  localparam logic [KeyIdxW-1:0] KEY_WORD_TWO   = 2'd2;
  localparam logic [KeyIdxW-1:0] KEY_WORD_THREE = 2'd3;

  typedef logic [KeyWords-1:0][WordW-1:0] key_arr_t;

  typedef struct packed {
    logic [WordW-1:0] mix_word;
    logic [1:0]       nonce_count;
    logic [WordW-1:0] data_count;
  } cipher_state_t;

endpackage

/* sv/kbsc_key_regs.sv */
// ----------------------------------------------------------------------------
// kbsc_key_regs
// Four 32-bit key word registers written through the configuration channel.
// ----------------------------------------------------------------------------
module kbsc_key_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kbsc_pkg::KeyIdxW-1:0]  cfg_index_i,
  input  logic [kbsc_pkg::WordW-1:0]    cfg_data_i,
  output kbsc_pkg::key_arr_t            key_o
);
  import kbsc_pkg::*;

  key_arr_t key_q, key_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        KEY_WORD_ZERO:  key_d[0] = cfg_data_i;
        KEY_WORD_ONE:   key_d[1] = cfg_data_i;
        KEY_WORD_TWO:   key_d[2] = cfg_data_i;
        KEY_WORD_THREE: key_d[3] = cfg_data_i;
        default:        key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

/* sv/kbsc_mix.sv */
// ----------------------------------------------------------------------------
// kbsc_mix
// One cipher step: next mixing state and keystream output for one item.
// ----------------------------------------------------------------------------
module kbsc_mix (
  input  logic [kbsc_pkg::OpW-1:0]   op_i,
  input  logic [kbsc_pkg::ByteW-1:0] byte_i,
  input  kbsc_pkg::key_arr_t         key_i,
  input  kbsc_pkg::cipher_state_t    state_i,
  output kbsc_pkg::cipher_state_t    state_o,
  output logic [kbsc_pkg::ByteW-1:0] byte_o,
  output logic                       emit_o
);
  import kbsc_pkg::*;

  logic [1:0]       nonce_lane;
  logic [1:0]       data_lane;
  logic [WordW-1:0] nonce_x, nonce_s, nonce_w;
  logic [WordW-1:0] data_x, data_p, data_s, data_w;

  assign nonce_lane = state_i.nonce_count;
  assign data_lane  = state_i.data_count[1:0];

  // nonce path: xor byte into lane, add golden constant and lane key word, rotate left 7
  assign nonce_x = state_i.mix_word ^ ({24'b0, byte_i} << {nonce_lane, 3'b000});
  assign nonce_s = nonce_x + GoldenConst + key_i[nonce_lane];
  assign nonce_w = {nonce_s[24:0], nonce_s[31:25]};

  // data path: xor key plus count, lcg, rotate left 11
  assign data_x = state_i.mix_word ^ (key_i[data_lane] + state_i.data_count);
  assign data_p = data_x * LcgMul;
  assign data_s = data_p + LcgAdd;
  assign data_w = {data_s[20:0], data_s[31:21]};

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    byte_o  = byte_i ^ data_w[{data_lane, 3'b000} +: 8];
    unique case (op_i)
      OP_START: begin
        state_o.mix_word    = InitConst ^ key_i[0];
        state_o.nonce_count = 2'd0;
        state_o.data_count  = '0;
      end
      OP_NONCE: begin
        state_o.mix_word    = nonce_w;
        state_o.nonce_count = nonce_lane + 2'd1;
      end
      OP_DATA: begin
        state_o.mix_word   = data_w;
        state_o.data_count = state_i.data_count + 32'd1;
        emit_o             = 1'b1;
      end
      default: state_o = state_i;
    endcase
  end

endmodule

/* sv/keyed_byte_stream_cipher_top.sv */
// ----------------------------------------------------------------------------
// keyed_byte_stream_cipher_top
// Byte stream cipher with a 128-bit key; encrypts and decrypts alike.
// ----------------------------------------------------------------------------
// usage:
//   config channel writes key words 0..3 (index 0 = key bytes 0..3, big-endian)
//   input stream: tuser carries the operation (start, nonce byte, data byte),
//   tdata carries the byte; a start beat reloads the mixing word and clears
//   both counters, nonce beats stir the word with no output
//   output stream: one beat per data beat, byte xor keystream byte
// path: an accepted beat is held in the input register, the cipher step runs
//   between that register and the result register, and a data beat shows on
//   the output from the result register
// throughput: one beat per cycle while no data beat waits on a stalled output,
//   set by the state update (constant multiply, adds, rotate) for the next beat
// stall: while the output beat waits, one more beat is taken into the input
//   register; a data beat there then holds until the result is taken, while
//   start and nonce beats pass on without waiting
// reset: key words, mixing word and counters clear to zero, both stages empty
// ----------------------------------------------------------------------------
module keyed_byte_stream_cipher_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kbsc_pkg::KeyIdxW-1:0] cfg_index_i,
  input  logic [kbsc_pkg::WordW-1:0]   cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] byte_in
  input  logic [1:0]                   s_axis_tuser,   // [1:0] operation
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata    // [7:0] byte_out
);
  import kbsc_pkg::*;

  key_arr_t key;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [OpW-1:0]   in_op_q;
  logic [ByteW-1:0] in_byte_q;

  // cipher state
  cipher_state_t state_q, state_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;

  logic             step_emit;
  logic [ByteW-1:0] step_byte;
  logic             advance;
  logic             in_take;

  kbsc_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key)
  );

  kbsc_mix u_mix (
    .op_i    (in_op_q),
    .byte_i  (in_byte_q),
    .key_i   (key),
    .state_i (state_q),
    .state_o (state_d),
    .byte_o  (step_byte),
    .emit_o  (step_emit)
  );

  // a beat producing output needs room in the result register
  assign advance = in_valid_q && (!step_emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance && step_emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (advance && step_emit) begin
      out_byte_q <= step_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;

  // a held beat in the input stage stays there
  a_hold_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input stage dropped a stalled beat");

  // a new result only follows a data beat leaving the input stage
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> $past(advance && step_emit))
    else $error("result appeared without a data beat");

  // a start beat leaves both counters cleared
  a_start_clr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_op_q == OP_START) |=>
      (state_q.nonce_count == 2'd0 && state_q.data_count == '0))
    else $error("start did not clear counters");

  // no output stall blocks an empty input stage
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input stage not ready");

endmodule
